// ===== rtl/saq_pkg.sv =====
// Shared types and codes for the sorted-array priority queue.
package saq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP_TOP   = 3'd1,
    CMD_POP_BACK  = 3'd2,
    CMD_EMP_FRONT = 3'd3,
    CMD_EMP_BACK  = 3'd4,
    CMD_QUERY     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2
  } cell_op_e;

  localparam logic signed [31:0] PrioMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] PrioMin = 32'sh8000_0000;

  // Broadcast from the controller to every cell in a cycle.
  typedef struct packed {
    cell_op_e           op;
    logic signed [31:0] prio;
  } bcast_t;

endpackage

// ===== rtl/saq_if.sv =====
// Handshake channels for command items and result items.
interface saq_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] item_value;
  logic signed [31:0] item_priority;

  modport source (output valid, output cmd, output item_value, output item_priority,
                  input ready);
  modport sink   (input valid, input cmd, input item_value, input item_priority,
                  output ready);
endinterface

interface saq_res_if #(
  parameter int CountWidth = 5
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [CountWidth-1:0] entry_count;
  logic                  is_empty;
  logic signed [31:0]    front_value;
  logic signed [31:0]    front_priority;
  logic signed [31:0]    back_value;
  logic signed [31:0]    back_priority;

  modport source (output valid, output status, output entry_count, output is_empty,
                  output front_value, output front_priority, output back_value,
                  output back_priority, input ready);
  modport sink   (input valid, input status, input entry_count, input is_empty,
                  input front_value, input front_priority, input back_value,
                  input back_priority, output ready);
endinterface

// ===== rtl/sorted_array_priority_queue.sv =====
// Sorted-array priority queue top level: a chain of DEPTH slot cells and the controller.
// The result of a command item is registered when the item is accepted.
// Throughput: one command item per cycle while the result is taken or none is pending; every
// cell compares and shifts in parallel, so the cell compare plus the front-slot select set the cycle.
// Reset: count and tracked end priorities clear at once; slot contents stay unknown
// until written and are never read while unoccupied. No clearing pass is needed.
module sorted_array_priority_queue #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  saq_cmd_if.sink        in_i,
  saq_res_if.source      res_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdxW = $clog2(DEPTH);

  logic [CntW-1:0]        count_q, count_d;
  logic signed [31:0]     top_q, bot_q;
  logic                   out_valid_q;
  logic                   accept;
  logic                   full, empty;
  logic [1:0]             status_d;
  saq_pkg::bcast_t        bcast;
  logic [VALUE_WIDTH-1:0] new_value;
  logic [IdxW-1:0]        fidx;

  logic                   le     [DEPTH];
  logic                   le_in  [DEPTH];
  logic [VALUE_WIDTH-1:0] val_q  [DEPTH];
  logic signed [31:0]     pri_q  [DEPTH];
  logic [VALUE_WIDTH-1:0] val_d  [DEPTH];
  logic signed [31:0]     pri_d  [DEPTH];

  logic [1:0]             status_q;
  logic signed [31:0]     fval_q, fpri_q, bval_q, bpri_q;

  assign in_i.ready = !out_valid_q || res_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = count_q == CntW'(DEPTH);
  assign empty      = count_q == '0;
  assign new_value  = VALUE_WIDTH'($unsigned(in_i.item_value));

  always_comb begin
    status_d   = saq_pkg::ST_OK;
    bcast.op   = saq_pkg::OP_HOLD;
    bcast.prio = in_i.item_priority;
    count_d    = count_q;
    unique case (in_i.cmd)
      saq_pkg::CMD_PUSH, saq_pkg::CMD_EMP_FRONT, saq_pkg::CMD_EMP_BACK: begin
        if (in_i.cmd == saq_pkg::CMD_EMP_FRONT) begin
          bcast.prio = top_q + 32'sd1;
        end else if (in_i.cmd == saq_pkg::CMD_EMP_BACK) begin
          bcast.prio = bot_q - 32'sd1;
        end
        priority if (full) begin
          status_d = saq_pkg::ST_FULL;
        end else if (in_i.cmd == saq_pkg::CMD_EMP_FRONT && top_q == saq_pkg::PrioMax) begin
          status_d = saq_pkg::ST_OVERFLOW;
        end else if (in_i.cmd == saq_pkg::CMD_EMP_BACK && bot_q == saq_pkg::PrioMin) begin
          status_d = saq_pkg::ST_OVERFLOW;
        end else begin
          bcast.op = saq_pkg::OP_INSERT;
          count_d  = count_q + CntW'(1);
        end
      end
      saq_pkg::CMD_POP_TOP, saq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          status_d = saq_pkg::ST_EMPTY;
        end else begin
          if (in_i.cmd == saq_pkg::CMD_POP_BACK) begin
            bcast.op = saq_pkg::OP_SHIFT;
          end
          count_d = count_q - CntW'(1);
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      bcast.op = saq_pkg::OP_HOLD;
      count_d  = count_q;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign le_in[i] = 1'b1;
    end else begin : g_rest
      assign le_in[i] = le[i-1];
    end

    saq_cell #(
      .ValueWidth (VALUE_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .bcast_i      (bcast),
      .new_value_i  (new_value),
      .occupied_i   (CntW'(i) < count_q),
      .le_prev_i    (le_in[i]),
      .prev_value_i (val_q[(i == 0) ? 0 : i-1]),
      .prev_prio_i  (pri_q[(i == 0) ? 0 : i-1]),
      .next_value_i (val_q[(i == DEPTH-1) ? i : i+1]),
      .next_prio_i  (pri_q[(i == DEPTH-1) ? i : i+1]),
      .le_o         (le[i]),
      .value_o      (val_q[i]),
      .prio_o       (pri_q[i]),
      .value_d_o    (val_d[i]),
      .prio_d_o     (pri_d[i])
    );
  end

  assign fidx = IdxW'(count_d - CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      top_q       <= '0;
      bot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
        // track the ends; keep the last values once the queue drains
        if (count_d != '0) begin
          top_q <= pri_d[fidx];
          bot_q <= pri_d[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      if (count_d == '0) begin
        fval_q <= '0;
        fpri_q <= '0;
        bval_q <= '0;
        bpri_q <= '0;
      end else begin
        fval_q <= $signed(32'(val_d[fidx]));
        fpri_q <= pri_d[fidx];
        bval_q <= $signed(32'(val_d[0]));
        bpri_q <= pri_d[0];
      end
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.status         = status_q;
  assign res_o.entry_count    = count_q;
  assign res_o.is_empty       = empty;
  assign res_o.front_value    = fval_q;
  assign res_o.front_priority = fpri_q;
  assign res_o.back_value     = bval_q;
  assign res_o.back_priority  = bpri_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count exceeds depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.cmd == saq_pkg::CMD_PUSH && !full |=> count_q == $past(count_q) + CntW'(1))
    else $error("accepted push did not add an entry");

  a_sorted_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !empty |-> fpri_q >= bpri_q)
    else $error("front priority below back priority");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && empty |-> fpri_q == '0 && bpri_q == '0 && fval_q == '0 && bval_q == '0)
    else $error("empty queue reports nonzero entries");
`endif

endmodule

// ===== rtl/saq_cell.sv =====
// One slot of the sorted chain: compares against the broadcast priority and shifts.
module saq_cell #(
  parameter int ValueWidth = 32
) (
  input  logic                  clk_i,
  input  saq_pkg::bcast_t       bcast_i,
  input  logic [ValueWidth-1:0] new_value_i,
  input  logic                  occupied_i,
  input  logic                  le_prev_i,
  input  logic [ValueWidth-1:0] prev_value_i,
  input  logic signed [31:0]    prev_prio_i,
  input  logic [ValueWidth-1:0] next_value_i,
  input  logic signed [31:0]    next_prio_i,
  output logic                  le_o,
  output logic [ValueWidth-1:0] value_o,
  output logic signed [31:0]    prio_o,
  output logic [ValueWidth-1:0] value_d_o,
  output logic signed [31:0]    prio_d_o
);

  logic [ValueWidth-1:0] value_q, value_d;
  logic signed [31:0]    prio_q, prio_d;

  assign le_o = occupied_i && (prio_q <= bcast_i.prio);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    unique case (bcast_i.op)
      saq_pkg::OP_INSERT: begin
        // keep entries at or below the new priority, drop the new one at the boundary
        if (!le_o) begin
          if (le_prev_i) begin
            value_d = new_value_i;
            prio_d  = bcast_i.prio;
          end else begin
            value_d = prev_value_i;
            prio_d  = prev_prio_i;
          end
        end
      end
      saq_pkg::OP_SHIFT: begin
        value_d = next_value_i;
        prio_d  = next_prio_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o   = value_q;
  assign prio_o    = prio_q;
  assign value_d_o = value_d;
  assign prio_d_o  = prio_d;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the sorted-array priority queue: directed cases, then random traffic.
`timescale 1ns / 100ps

module tb;

  localparam int QueueDepth = 16;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 4;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  typedef struct {
    saq_pkg::status_e   status;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic signed [31:0] front_value;
    logic signed [31:0] front_priority;
    logic signed [31:0] back_value;
    logic signed [31:0] back_priority;
  } queue_result_t;

  logic clk_i;
  logic rst_ni;

  saq_cmd_if cmd_ch ();
  saq_res_if #(.CountWidth(5)) res_ch ();

  sorted_array_priority_queue #(
    .DEPTH      (QueueDepth),
    .VALUE_WIDTH(32)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch),
    .res_o (res_ch)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the queue contents, ascending by priority; slot 0 is the back.
  logic signed [31:0] shadow_value[QueueDepth];
  logic signed [31:0] shadow_prio[QueueDepth];
  int                 shadow_count = 0;
  logic signed [31:0] top_seen = '0;
  logic signed [31:0] bottom_seen = '0;

  queue_result_t pending_results[$];

  int fail_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int full_seen = 0;
  int empty_seen = 0;
  int overflow_seen = 0;
  int cycle_count = 0;

  int  burst_left = 0;
  bit  gaps_on = 1'b1;

  logic [1:0]  stall_mode = 2'd0;
  logic [15:0] stall_pattern = 16'hffff;
  logic [7:0]  stall_cycle = 8'd0;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void refresh_ends();
    if (shadow_count > 0) begin
      top_seen = shadow_prio[shadow_count-1];
      bottom_seen = shadow_prio[0];
    end
  endfunction

  // Place after every entry of equal or lower priority so ties keep newest nearest the front.
  function automatic void insert_slot(input logic signed [31:0] value,
                                      input logic signed [31:0] prio);
    int pos;
    pos = 0;
    while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
    for (int i = shadow_count; i > pos; i--) begin
      shadow_value[i] = shadow_value[i-1];
      shadow_prio[i] = shadow_prio[i-1];
    end
    shadow_value[pos] = value;
    shadow_prio[pos] = prio;
    shadow_count++;
    refresh_ends();
  endfunction

  function automatic queue_result_t predict_queue_step(input logic [2:0] cmd,
                                                       input logic signed [31:0] value,
                                                       input logic signed [31:0] prio);
    queue_result_t r;
    r.status = saq_pkg::ST_OK;
    case (cmd)
      saq_pkg::CMD_PUSH, saq_pkg::CMD_EMP_FRONT, saq_pkg::CMD_EMP_BACK: begin
        if (shadow_count >= QueueDepth) begin
          r.status = saq_pkg::ST_FULL;
        end else if (cmd == saq_pkg::CMD_PUSH) begin
          insert_slot(value, prio);
        end else if (cmd == saq_pkg::CMD_EMP_FRONT) begin
          if (top_seen == saq_pkg::PrioMax) r.status = saq_pkg::ST_OVERFLOW;
          else insert_slot(value, top_seen + 32'sd1);
        end else begin
          if (bottom_seen == saq_pkg::PrioMin) r.status = saq_pkg::ST_OVERFLOW;
          else insert_slot(value, bottom_seen - 32'sd1);
        end
      end
      saq_pkg::CMD_POP_TOP, saq_pkg::CMD_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = saq_pkg::ST_EMPTY;
        end else begin
          if (cmd == saq_pkg::CMD_POP_BACK) begin
            for (int i = 1; i < shadow_count; i++) begin
              shadow_value[i-1] = shadow_value[i];
              shadow_prio[i-1] = shadow_prio[i];
            end
          end
          shadow_count--;
          refresh_ends();
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_count[4:0];
    r.is_empty = (shadow_count == 0);
    if (shadow_count == 0) begin
      r.front_value = '0;
      r.front_priority = '0;
      r.back_value = '0;
      r.back_priority = '0;
    end else begin
      r.front_value = shadow_value[shadow_count-1];
      r.front_priority = shadow_prio[shadow_count-1];
      r.back_value = shadow_value[0];
      r.back_priority = shadow_prio[0];
    end
    return r;
  endfunction

  // Send one command item; idle between bursts when gaps are enabled.
  task automatic issue_command(input logic [2:0] cmd, input logic signed [31:0] value,
                               input logic signed [31:0] prio);
    int gap;
    queue_result_t r;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd <= cmd;
    cmd_ch.item_value <= value;
    cmd_ch.item_priority <= prio;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    r = predict_queue_step(cmd, value, prio);
    pending_results.push_back(r);
    items_sent++;
    if (r.status == saq_pkg::ST_FULL) full_seen++;
    if (r.status == saq_pkg::ST_EMPTY) empty_seen++;
    if (r.status == saq_pkg::ST_OVERFLOW) overflow_seen++;
  endtask

  // Hold the sender until every expected result is back.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    queue_result_t exp;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        note_failure("result with no command outstanding");
      end else begin
        exp = pending_results[0];
        pending_results.delete(0);
        results_checked++;
        if (res_ch.status !== exp.status || res_ch.entry_count !== exp.entry_count ||
            res_ch.is_empty !== exp.is_empty || res_ch.front_value !== exp.front_value ||
            res_ch.front_priority !== exp.front_priority ||
            res_ch.back_value !== exp.back_value ||
            res_ch.back_priority !== exp.back_priority) begin
          note_failure($sformatf(
            "exp st=%0d n=%0d e=%0b f=%0d/%0d b=%0d/%0d got st=%0d n=%0d e=%0b f=%0d/%0d b=%0d/%0d",
            exp.status, exp.entry_count, exp.is_empty, exp.front_value, exp.front_priority,
            exp.back_value, exp.back_priority, res_ch.status, res_ch.entry_count,
            res_ch.is_empty, res_ch.front_value, res_ch.front_priority, res_ch.back_value,
            res_ch.back_priority));
        end
      end
    end
    // Pick a new stall pattern each time the 8-bit stall_cycle counter wraps to zero.
    if (stall_cycle == 8'd0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_pattern <= 16'($urandom) | 16'h0001;
    end
    stall_cycle <= stall_cycle + 8'd1;
    case (stall_mode)
      2'd0: res_ch.ready <= 1'b1;
      2'd1: res_ch.ready <= 1'($urandom_range(0, 1));
      2'd2: res_ch.ready <= stall_pattern[stall_cycle[3:0]];
      default: res_ch.ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL sorted_array_priority_queue");
      $finish;
    end
  end

  task automatic test_empty_queue();
    issue_command(saq_pkg::CMD_QUERY, 32'sd0, 32'sd0);
    issue_command(saq_pkg::CMD_POP_TOP, 32'sd0, 32'sd0);
    issue_command(saq_pkg::CMD_POP_BACK, 32'sd0, 32'sd0);
    issue_command(CmdSpare7, 32'($urandom), 32'($urandom));
  endtask

  // Tracked ends keep their last values once the queue empties.
  task automatic test_emplace_tracking();
    issue_command(saq_pkg::CMD_PUSH, saq_pkg::PrioMax, 32'sd100);
    issue_command(saq_pkg::CMD_POP_TOP, 32'sd0, 32'sd0);
    issue_command(saq_pkg::CMD_EMP_BACK, -32'sd1, 32'($urandom));
    issue_command(saq_pkg::CMD_POP_BACK, 32'sd0, 32'sd0);
    issue_command(saq_pkg::CMD_EMP_FRONT, 32'sd7, 32'sd0);
    issue_command(saq_pkg::CMD_POP_TOP, 32'sd0, 32'sd0);
  endtask

  task automatic test_priority_extremes();
    issue_command(saq_pkg::CMD_PUSH, saq_pkg::PrioMax, saq_pkg::PrioMax);
    issue_command(saq_pkg::CMD_PUSH, saq_pkg::PrioMin, saq_pkg::PrioMin);
    issue_command(saq_pkg::CMD_EMP_FRONT, 32'sd3, 32'sd0);
    issue_command(saq_pkg::CMD_EMP_BACK, 32'sd4, 32'sd0);
    issue_command(saq_pkg::CMD_PUSH, 32'sd1, 32'sd0);
    issue_command(saq_pkg::CMD_PUSH, 32'sd2, 32'sd0);
    issue_command(saq_pkg::CMD_POP_BACK, 32'sd0, 32'sd0);
  endtask

  // Fill up with the maximum priority still held, so full must win over overflow.
  task automatic test_full_queue();
    while (shadow_count < QueueDepth)
      issue_command(saq_pkg::CMD_PUSH, 32'($urandom), 32'($urandom_range(0, 6)) - 32'sd3);
    issue_command(saq_pkg::CMD_PUSH, 32'($urandom), 32'sd0);
    issue_command(saq_pkg::CMD_EMP_FRONT, 32'($urandom), 32'sd0);
  endtask

  task automatic test_random_mix();
    int kind;
    int roll;
    logic [2:0] cmd;
    logic signed [31:0] prio;
    for (int phase = 0; phase < 12; phase++) begin
      kind = phase % 3;
      gaps_on = ($urandom_range(0, 3) != 0);
      if (phase == 6) drain_results();
      for (int n = 0; n < 50; n++) begin
        roll = $urandom_range(0, 99);
        // Fill phases favor inserts, drain phases favor pops, the rest is balanced.
        if (kind == 0) begin
          if (roll < 50) cmd = saq_pkg::CMD_PUSH;
          else if (roll < 65) cmd = saq_pkg::CMD_EMP_FRONT;
          else if (roll < 80) cmd = saq_pkg::CMD_EMP_BACK;
          else if (roll < 85) cmd = saq_pkg::CMD_POP_TOP;
          else if (roll < 90) cmd = saq_pkg::CMD_POP_BACK;
          else cmd = 3'($urandom_range(saq_pkg::CMD_QUERY, CmdSpare7));
        end else if (kind == 1) begin
          if (roll < 15) cmd = saq_pkg::CMD_PUSH;
          else if (roll < 20) cmd = saq_pkg::CMD_EMP_FRONT;
          else if (roll < 25) cmd = saq_pkg::CMD_EMP_BACK;
          else if (roll < 55) cmd = saq_pkg::CMD_POP_TOP;
          else if (roll < 85) cmd = saq_pkg::CMD_POP_BACK;
          else cmd = 3'($urandom_range(saq_pkg::CMD_QUERY, CmdSpare7));
        end else begin
          cmd = 3'($urandom_range(0, 7));
        end
        roll = $urandom_range(0, 9);
        if (roll < 6) prio = 32'($urandom_range(0, 16)) - 32'sd8;
        else if (roll < 8) prio = 32'($urandom);
        else if (roll == 8) prio = saq_pkg::PrioMax - 32'($urandom_range(0, 2));
        else prio = saq_pkg::PrioMin + 32'($urandom_range(0, 2));
        issue_command(cmd, 32'($urandom), prio);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.cmd <= saq_pkg::CMD_QUERY;
    cmd_ch.item_value <= '0;
    cmd_ch.item_priority <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_emplace_tracking();
    drain_results();
    test_priority_extremes();
    test_full_queue();
    test_random_mix();

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    $display("run: %0d commands sent, %0d results checked, %0d mismatches", items_sent,
             results_checked, fail_count);
    $display("rejects seen: %0d full, %0d empty pop, %0d priority overflow", full_seen,
             empty_seen, overflow_seen);
    if (fail_count == 0) begin
      $display("PASS sorted_array_priority_queue");
    end else begin
      $display("FAIL sorted_array_priority_queue");
    end
    $finish;
  end

endmodule
